[rtl/cte_pkg.sv]
package cte_pkg;

    // Command codes
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_NEXT      = 3'd1;
    localparam logic [2:0] CMD_INC       = 3'd2;
    localparam logic [2:0] CMD_DEC       = 3'd3;
    localparam logic [2:0] CMD_LOAD      = 3'd4;
    localparam logic [2:0] CMD_SEL_RESET = 3'd5;

    // Field indexes for the selection pointer
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DATE   = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    // Field limits
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINSEC_MAX = 7'd59;

    localparam logic [4:0] DAYS_28 = 5'd28;
    localparam logic [4:0] DAYS_29 = 5'd29;
    localparam logic [4:0] DAYS_30 = 5'd30;
    localparam logic [4:0] DAYS_31 = 5'd31;

    // Year within century that lands on 2100, the only non-leap multiple of four
    localparam logic [6:0] YEAR_2100 = 7'd100;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_date;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } cte_req_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] selected_field;
        logic [4:0] month_days;
        logic       date_clamped;
    } cte_rsp_t;

    // Editor state carried between the step logic and the top level
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] sel;
        logic [4:0] days;
    } cte_state_t;

    // Days in month; year counts from 2000, months outside 1..12 give 30
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [6:0] year);
        logic leap;
        logic [4:0] days;
        leap = (year[1:0] == 2'b00) && (year != YEAR_2100);
        case (month)
            4'd2: days = leap ? DAYS_29 : DAYS_28;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = DAYS_31;
            default: days = DAYS_30;
        endcase
        return days;
    endfunction

endpackage

[rtl/cte_step.sv]
module cte_step (
    input  cte_pkg::cte_state_t state_i,
    input  cte_pkg::cte_req_t   req_i,
    output cte_pkg::cte_state_t state_o,
    output cte_pkg::cte_rsp_t   rsp_o
);
    import cte_pkg::*;

    cte_state_t st;
    logic [2:0] sel_cur;
    logic [2:0] sel_new;
    logic [6:0] cur_val;
    logic [6:0] fmax;
    logic       low_one;
    logic [6:0] low_val;
    logic [7:0] inc_sum;
    logic [6:0] inc_val;
    logic [6:0] dec_val;
    logic [6:0] new_val;
    logic       wr_field;
    logic       edit;
    logic       clamped;
    logic [4:0] new_days;

    // Pick the selected field, its maximum and its lower bound
    always_comb begin
        sel_cur = (state_i.sel > FLD_SECOND) ? FLD_YEAR : state_i.sel;
        case (sel_cur)
            FLD_YEAR: begin
                cur_val = state_i.year;
                fmax    = YEAR_MAX;
            end
            FLD_MONTH: begin
                cur_val = {3'b000, state_i.month};
                fmax    = MONTH_MAX;
            end
            FLD_DATE: begin
                cur_val = {2'b00, state_i.date};
                fmax    = {2'b00, state_i.days};
            end
            FLD_HOUR: begin
                cur_val = {2'b00, state_i.hour};
                fmax    = HOUR_MAX;
            end
            FLD_MINUTE: begin
                cur_val = {1'b0, state_i.minute};
                fmax    = MINSEC_MAX;
            end
            default: begin
                cur_val = {1'b0, state_i.second};
                fmax    = MINSEC_MAX;
            end
        endcase
        low_one = (sel_cur == FLD_MONTH) || (sel_cur == FLD_DATE);
        low_val = {6'b000000, low_one};
    end

    // Wrap-around step up and down
    always_comb begin
        inc_sum = {1'b0, cur_val} + 8'd1;
        inc_val = (inc_sum > {1'b0, fmax}) ? low_val : inc_sum[6:0];
        dec_val = (cur_val <= low_val) ? fmax : (cur_val - 7'd1);
    end

    // Apply command; edits at year/month refresh month days, clamp date
    always_comb begin
        st       = state_i;
        sel_new  = sel_cur;
        edit     = 1'b1;
        wr_field = 1'b0;
        new_val  = inc_val;
        clamped  = 1'b0;
        new_days = DAYS_31;

        unique case (req_i.command)
            CMD_NEXT: sel_new = (sel_cur >= FLD_SECOND) ? FLD_YEAR : sel_cur + 3'd1;
            CMD_INC: begin
                wr_field = 1'b1;
                new_val  = inc_val;
            end
            CMD_DEC: begin
                wr_field = 1'b1;
                new_val  = dec_val;
            end
            CMD_LOAD: begin
                edit = 1'b0;
                if (req_i.load_second != state_i.second) begin
                    st.year   = req_i.load_year;
                    st.month  = req_i.load_month;
                    st.date   = req_i.load_date;
                    st.hour   = req_i.load_hour;
                    st.minute = req_i.load_minute;
                    st.second = req_i.load_second;
                end
            end
            CMD_SEL_RESET: begin
                edit    = 1'b0;
                sel_new = FLD_YEAR;
            end
            default: ;
        endcase

        if (wr_field) begin
            case (sel_cur)
                FLD_YEAR:   st.year   = new_val;
                FLD_MONTH:  st.month  = new_val[3:0];
                FLD_DATE:   st.date   = new_val[4:0];
                FLD_HOUR:   st.hour   = new_val[4:0];
                FLD_MINUTE: st.minute = new_val[5:0];
                default:    st.second = new_val[5:0];
            endcase
        end
        st.sel = sel_new;

        if (edit && ((sel_new == FLD_YEAR) || (sel_new == FLD_MONTH))) begin
            new_days = month_length(st.month, st.year);
            st.days  = new_days;
            if (st.date > new_days) begin
                st.date = new_days;
                clamped = 1'b1;
            end
        end
    end

    assign state_o = st;

    always_comb begin
        rsp_o.year           = st.year;
        rsp_o.month          = st.month;
        rsp_o.date           = st.date;
        rsp_o.hour           = st.hour;
        rsp_o.minute         = st.minute;
        rsp_o.second         = st.second;
        rsp_o.selected_field = st.sel;
        rsp_o.month_days     = st.days;
        rsp_o.date_clamped   = clamped;
    end

endmodule

[rtl/clock_time_set_editor_top.sv]
// Time-set editor for a calendar clock: holds year (within the century), month,
// date, hour, minute and second, a pointer to the field being edited and the
// current month length. Each request carries one command (next field, step up,
// step down, load from a clock reading, reset selection, or none) and returns
// one response with all fields after the command. The block takes one request
// per cycle while m_ready does not stall the output; a request is held in the
// input register and its response is then registered in the result register.
// The editor state is updated as the request moves into the result register,
// so back-to-back requests see each other's effect. After reset all fields are
// zero, the year field is selected and the month length is 31.
module clock_time_set_editor_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cte_pkg::cte_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cte_pkg::cte_rsp_t m_data
);
    import cte_pkg::*;

    cte_req_t   req_reg;
    logic       in_valid_reg;
    cte_rsp_t   rsp_reg;
    logic       out_valid_reg;
    cte_state_t state_reg;
    cte_state_t state_next;
    cte_rsp_t   rsp_next;
    logic       out_adv;
    logic       step_fire;

    assign out_adv   = !out_valid_reg || m_ready;
    assign step_fire = in_valid_reg && out_adv;
    assign s_ready   = !in_valid_reg || out_adv;

    cte_step u_step (
        .state_i (state_reg),
        .req_i   (req_reg),
        .state_o (state_next),
        .rsp_o   (rsp_next)
    );

    // Hold the accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // Advance the editor state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            state_reg.year   <= '0;
            state_reg.month  <= '0;
            state_reg.date   <= '0;
            state_reg.hour   <= '0;
            state_reg.minute <= '0;
            state_reg.second <= '0;
            state_reg.sel    <= FLD_YEAR;
            state_reg.days   <= DAYS_31;
        end else begin
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = rsp_reg;

endmodule

[tb/sv/clock_time_set_editor_top_tb.sv]
`timescale 1ns / 100ps

module clock_time_set_editor_top_tb;
    import cte_pkg::*;

    // Spare command codes, decoded as no command
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int RAND_ITEMS   = 800;
    localparam int DRAIN_CYCLES = 8;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    cte_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    cte_rsp_t m_data;

    // Shadow copy of the editor state
    logic [6:0] clock_fields [6];
    logic [2:0] edit_ptr;
    logic [4:0] month_limit;

    cte_rsp_t predicted_time_q [$];
    cte_req_t table_req [$];
    bit       table_fixed [$];
    cte_rsp_t table_rsp [$];
    int       errors = 0;

    clock_time_set_editor_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Days in month, Gregorian rule on 2000 + year; bad months give 30
    function automatic logic [4:0] days_of_month(logic [6:0] mon, logic [6:0] yr);
        int full;
        logic [4:0] days;
        full = 2000 + yr;
        case (mon)
            7'd2: begin
                if ((full % 4 == 0 && full % 100 != 0) || full % 400 == 0)
                    days = DAYS_29;
                else
                    days = DAYS_28;
            end
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = DAYS_31;
            default: days = DAYS_30;
        endcase
        return days;
    endfunction

    function automatic logic [6:0] field_top(logic [2:0] f);
        logic [6:0] top;
        case (f)
            FLD_YEAR:  top = YEAR_MAX;
            FLD_MONTH: top = MONTH_MAX;
            FLD_DATE:  top = {2'b00, month_limit};
            FLD_HOUR:  top = HOUR_MAX;
            default:   top = MINSEC_MAX;
        endcase
        return top;
    endfunction

    // Apply one command to the shadow state and return the fields after it
    function automatic cte_rsp_t edit_clock_fields(cte_req_t req);
        logic [2:0] sel;
        logic [7:0] v;
        logic [7:0] lo;
        bit         refresh;
        bit         clamped;
        cte_rsp_t   rsp;
        sel     = (edit_ptr > FLD_SECOND) ? FLD_YEAR : edit_ptr;
        refresh = 1'b1;
        clamped = 1'b0;
        lo      = (sel == FLD_MONTH || sel == FLD_DATE) ? 8'd1 : 8'd0;
        case (req.command)
            CMD_NEXT: sel = (sel >= FLD_SECOND) ? FLD_YEAR : sel + 3'd1;
            CMD_INC: begin
                v = {1'b0, clock_fields[sel]} + 8'd1;
                if (v > {1'b0, field_top(sel)})
                    v = lo;
                clock_fields[sel] = v[6:0];
            end
            CMD_DEC: begin
                v = {1'b0, clock_fields[sel]};
                if (v <= lo)
                    v = {1'b0, field_top(sel)};
                else
                    v = v - 8'd1;
                clock_fields[sel] = v[6:0];
            end
            CMD_LOAD: begin
                refresh = 1'b0;
                if ({1'b0, req.load_second} != clock_fields[FLD_SECOND]) begin
                    clock_fields[FLD_YEAR]   = req.load_year;
                    clock_fields[FLD_MONTH]  = {3'b000, req.load_month};
                    clock_fields[FLD_DATE]   = {2'b00, req.load_date};
                    clock_fields[FLD_HOUR]   = {2'b00, req.load_hour};
                    clock_fields[FLD_MINUTE] = {1'b0, req.load_minute};
                    clock_fields[FLD_SECOND] = {1'b0, req.load_second};
                end
            end
            CMD_SEL_RESET: begin
                refresh = 1'b0;
                sel     = FLD_YEAR;
            end
            default: ;
        endcase
        edit_ptr = sel;

        // With refresh and year or month selected, recompute month length and clamp date
        if (refresh && (sel == FLD_YEAR || sel == FLD_MONTH)) begin
            month_limit = days_of_month(clock_fields[FLD_MONTH], clock_fields[FLD_YEAR]);
            if (clock_fields[FLD_DATE] > {2'b00, month_limit}) begin
                clock_fields[FLD_DATE] = {2'b00, month_limit};
                clamped = 1'b1;
            end
        end

        rsp.year           = clock_fields[FLD_YEAR];
        rsp.month          = clock_fields[FLD_MONTH][3:0];
        rsp.date           = clock_fields[FLD_DATE][4:0];
        rsp.hour           = clock_fields[FLD_HOUR][4:0];
        rsp.minute         = clock_fields[FLD_MINUTE][5:0];
        rsp.second         = clock_fields[FLD_SECOND][5:0];
        rsp.selected_field = edit_ptr;
        rsp.month_days     = month_limit;
        rsp.date_clamped   = clamped;
        return rsp;
    endfunction

    function automatic cte_req_t mk_req(logic [2:0] c, logic [6:0] y, logic [3:0] mo,
                                        logic [4:0] d, logic [4:0] h, logic [5:0] mi,
                                        logic [5:0] s);
        return {c, y, mo, d, h, mi, s};
    endfunction

    function automatic cte_rsp_t mk_fields(logic [6:0] y, logic [3:0] mo, logic [4:0] d,
                                           logic [4:0] h, logic [5:0] mi, logic [5:0] s,
                                           logic [2:0] sel, logic [4:0] days);
        return {y, mo, d, h, mi, s, sel, days, 1'b0};
    endfunction

    task automatic add_row(cte_req_t req, bit fixed, cte_rsp_t rsp);
        table_req.push_back(req);
        table_fixed.push_back(fixed);
        table_rsp.push_back(rsp);
    endtask

    // Draw one request: mostly edits, some clock loads, a little noise
    function automatic cte_req_t random_request();
        cte_req_t r;
        int       pick;
        pick          = $urandom_range(0, 99);
        r.load_year   = 7'($urandom_range(0, 127));
        r.load_month  = 4'($urandom_range(0, 15));
        r.load_date   = 5'($urandom_range(0, 31));
        r.load_hour   = 5'($urandom_range(0, 31));
        r.load_minute = 6'($urandom_range(0, 63));
        r.load_second = 6'($urandom_range(0, 63));
        if (pick < 25)
            r.command = CMD_INC;
        else if (pick < 50)
            r.command = CMD_DEC;
        else if (pick < 70)
            r.command = CMD_NEXT;
        else if (pick < 80)
            r.command = CMD_LOAD;
        else if (pick < 85)
            r.command = CMD_SEL_RESET;
        else if (pick < 93)
            r.command = CMD_NONE;
        else
            r.command = 3'($urandom_range(0, 7));

        // Keep most loads in range, with February month ends often
        if (r.command == CMD_LOAD && $urandom_range(0, 3) != 0) begin
            r.load_year   = 7'($urandom_range(0, 99));
            r.load_month  = 4'($urandom_range(1, 12));
            r.load_date   = 5'($urandom_range(1, 31));
            r.load_hour   = 5'($urandom_range(0, 23));
            r.load_minute = 6'($urandom_range(0, 59));
            r.load_second = 6'($urandom_range(0, 59));
            if ($urandom_range(0, 3) == 0) begin
                r.load_month = 4'd2;
                r.load_date  = 5'($urandom_range(28, 31));
            end
        end
        if (r.command == CMD_LOAD && $urandom_range(0, 4) == 0)
            r.load_second = clock_fields[FLD_SECOND][5:0];
        return r;
    endfunction

    function automatic void flag_field(string name, int want, int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
    endfunction

    task automatic compare_response(cte_rsp_t want, cte_rsp_t got);
        if (got.year !== want.year)
            flag_field("year", int'(want.year), int'(got.year));
        if (got.month !== want.month)
            flag_field("month", int'(want.month), int'(got.month));
        if (got.date !== want.date)
            flag_field("date", int'(want.date), int'(got.date));
        if (got.hour !== want.hour)
            flag_field("hour", int'(want.hour), int'(got.hour));
        if (got.minute !== want.minute)
            flag_field("minute", int'(want.minute), int'(got.minute));
        if (got.second !== want.second)
            flag_field("second", int'(want.second), int'(got.second));
        if (got.selected_field !== want.selected_field)
            flag_field("selected_field", int'(want.selected_field),
                       int'(got.selected_field));
        if (got.month_days !== want.month_days)
            flag_field("month_days", int'(want.month_days), int'(got.month_days));
        if (got.date_clamped !== want.date_clamped)
            flag_field("date_clamped", int'(want.date_clamped), int'(got.date_clamped));
    endtask

    // Request side: reset, directed table, random requests, drain
    initial begin : request_side
        cte_req_t req;
        cte_rsp_t rsp;
        int       gap;
        int       total;
        int       hold_at;
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        clock_fields = '{default: 7'd0};
        edit_ptr    = FLD_YEAR;
        month_limit = DAYS_31;

        // Reset selection after reset, then a load at field maximums, year up and down
        add_row(mk_req(CMD_SEL_RESET, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_fields(0, 0, 0, 0, 0, 0, FLD_YEAR, DAYS_31));
        add_row(mk_req(CMD_LOAD, 99, 12, 31, 23, 59, 59), 1'b1,
                mk_fields(99, 12, 31, 23, 59, 59, FLD_YEAR, DAYS_31));
        add_row(mk_req(CMD_INC, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_fields(0, 12, 31, 23, 59, 59, FLD_YEAR, DAYS_31));
        add_row(mk_req(CMD_DEC, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_fields(99, 12, 31, 23, 59, 59, FLD_YEAR, DAYS_31));
        // Month wraps both ways
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        // February of a common year clamps the date
        add_row(mk_req(CMD_LOAD, 1, 2, 31, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_NONE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        // Load with equal seconds changes nothing
        add_row(mk_req(CMD_LOAD, 5, 6, 7, 8, 9, 0), 1'b0, '0);
        // Leap 2000, then the non-leap 2100 through a spare command
        add_row(mk_req(CMD_LOAD, 0, 2, 29, 0, 0, 1), 1'b0, '0);
        add_row(mk_req(CMD_NONE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD, 100, 2, 29, 0, 0, 2), 1'b0, '0);
        add_row(mk_req(CMD_SPARE6, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        // Out-of-range stored values on date and hour
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD, 127, 15, 31, 31, 63, 63), 1'b0, '0);
        add_row(mk_req(CMD_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_DEC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_INC, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        // Walk to the second field and wrap back to year with a bad month
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_SPARE7, 0, 0, 0, 0, 0, 0), 1'b0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        total   = table_req.size() + RAND_ITEMS;
        hold_at = table_req.size() + RAND_ITEMS / 2;
        for (int i = 0; i < total; i++) begin
            req = (i < table_req.size()) ? table_req[i] : random_request();
            gap = ((i % 128) >= 112) ? 0 : $urandom_range(0, 3);

            // Drop valid for the gap; once, hold until every response is back
            if (gap > 0 || i == hold_at) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                if (i == hold_at) begin
                    @(posedge aclk);
                    while (predicted_time_q.size() != 0) @(posedge aclk);
                end
            end

            s_valid <= 1'b1;
            s_data  <= req;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);

            rsp = edit_clock_fields(req);
            if (i < table_req.size() && table_fixed[i])
                rsp = table_rsp[i];
            predicted_time_q.push_back(rsp);
        end
        s_valid <= 1'b0;

        while (predicted_time_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[clock_time_set_editor_top] OK");
        else
            $display("[clock_time_set_editor_top] ERROR");
        $finish;
    end

    // Response side: random stalls, check each response against the oldest prediction
    initial begin : response_side
        cte_rsp_t want;
        int       stall;
        int       got_count;
        got_count = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ((got_count % 100) >= 85) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got_count++;
            if (predicted_time_q.size() == 0) begin
                $display("%0t: response with none predicted, actual %h", $time, m_data);
                errors++;
            end else begin
                want = predicted_time_q.pop_front();
                compare_response(want, m_data);
            end
        end
    end

    // Hard stop if the handshakes hang
    initial begin : watchdog
        #2000000;
        $display("[clock_time_set_editor_top] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/cte_pkg.sv
rtl/cte_step.sv
rtl/clock_time_set_editor_top.sv
tb/sv/clock_time_set_editor_top_tb.sv
